[hdl/rfm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rfm_pkg
// Shared types, register codes and per-axis arithmetic for the rectangular
// falloff mask pipeline.
// ----------------------------------------------------------------------------
package rfm_pkg;

  localparam int PIX_W  = 12;
  localparam int DIM_W  = 13;
  localparam int SHF_W  = 14;
  localparam int HGT_W  = 8;
  localparam int ADDR_W = 24;
  localparam int CIDX_W = 3;
  localparam int CDAT_W = 14;
  localparam int DST_W  = 15;
  localparam int DEN_W  = 14;
  localparam int REM_W  = 23;
  localparam int NCELL  = 8;

  localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

  localparam logic [CIDX_W-1:0] REG_MAP_WIDTH     = 3'd0;
  localparam logic [CIDX_W-1:0] REG_MAP_HEIGHT    = 3'd1;
  localparam logic [CIDX_W-1:0] REG_FLAT_RADIUS_X = 3'd2;
  localparam logic [CIDX_W-1:0] REG_FLAT_RADIUS_Y = 3'd3;
  localparam logic [CIDX_W-1:0] REG_RAMP_WIDTH_X  = 3'd4;
  localparam logic [CIDX_W-1:0] REG_RAMP_WIDTH_Y  = 3'd5;
  localparam logic [CIDX_W-1:0] REG_SHIFT_X       = 3'd6;
  localparam logic [CIDX_W-1:0] REG_SHIFT_Y       = 3'd7;

  typedef struct packed {
    logic [DIM_W-1:0]        map_width;
    logic [DIM_W-1:0]        map_height;
    logic [DIM_W-1:0]        flat_radius_x;
    logic [DIM_W-1:0]        flat_radius_y;
    logic [DIM_W-1:0]        ramp_width_x;
    logic [DIM_W-1:0]        ramp_width_y;
    logic signed [SHF_W-1:0] shift_x;
    logic signed [SHF_W-1:0] shift_y;
  } cfg_t;

  typedef struct packed {
    logic             full;
    logic             div;
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [HGT_W-1:0] quo;
  } axis_t;

  typedef struct packed {
    axis_t             ax_x;
    axis_t             ax_y;
    logic [ADDR_W-1:0] addr;
    logic              outside;
  } item_t;

  // doubled distance from the shifted centre, plus one when the size is odd
  function automatic logic [DST_W-1:0] axis_dist(
    input logic [PIX_W-1:0]        p,
    input logic [DIM_W-1:0]        s,
    input logic signed [SHF_W-1:0] o
  );
    logic signed [16:0] tp;
    logic signed [16:0] ts;
    logic signed [16:0] to;
    logic signed [16:0] t;
    logic signed [16:0] mag;
    tp = {4'b0, p, 1'b0};
    ts = {4'b0, s};
    to = {{2{o[SHF_W-1]}}, o, 1'b0};
    t = tp - ts + 17'sd1 - to;
    mag = t[16] ? -t : t;
    return mag[DST_W-1:0] + {{(DST_W-1){1'b0}}, s[0]};
  endfunction

  // classify and form the ramp numerator 255*(2f+2r-D) + f
  function automatic axis_t axis_prep(
    input logic [DST_W-1:0] d,
    input logic [DIM_W-1:0] r,
    input logic [DIM_W-1:0] f
  );
    axis_t             a;
    logic [DEN_W-1:0]  sum;
    logic [DST_W-1:0]  s2;
    logic [15:0]       g;
    logic              pos;
    logic [DEN_W-1:0]  gm;
    logic [21:0]       n;
    sum = {1'b0, f} + {1'b0, r};
    s2 = {sum, 1'b0};
    g = {1'b0, s2} - {1'b0, d};
    pos = !g[15] && (g != 16'd0);
    gm = g[DEN_W-1:0];
    n = {gm, 8'b0} - {8'b0, gm};
    a.full = d < {1'b0, r, 1'b0};
    a.div = !a.full && pos;
    a.rem = {1'b0, n} + {10'b0, f};
    a.den = {f, 1'b0};
    a.quo = '0;
    return a;
  endfunction

  function automatic logic [HGT_W-1:0] axis_height(input axis_t a);
    if (a.full) begin
      return 8'd255;
    end else if (a.div) begin
      return a.quo;
    end
    return 8'd0;
  endfunction

endpackage
`default_nettype wire

[hdl/rfm_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rfm_in_if
// Pixel coordinate channel with valid/ready transfer.
// ----------------------------------------------------------------------------
interface rfm_in_if;
  logic                       valid;
  logic                       ready;
  logic [rfm_pkg::PIX_W-1:0]  pix_x;
  logic [rfm_pkg::PIX_W-1:0]  pix_y;

  modport source (output valid, output pix_x, output pix_y, input ready);
  modport sink (input valid, input pix_x, input pix_y, output ready);
endinterface
`default_nettype wire

[hdl/rfm_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rfm_out_if
// Mask result channel with valid/ready transfer.
// ----------------------------------------------------------------------------
interface rfm_out_if;
  logic                        valid;
  logic                        ready;
  logic [rfm_pkg::HGT_W-1:0]   height_value;
  logic [rfm_pkg::ADDR_W-1:0]  pixel_address;
  logic                        outside_image;

  modport source (output valid, output height_value, output pixel_address,
                  output outside_image, input ready);
  modport sink (input valid, input height_value, input pixel_address,
                input outside_image, output ready);
endinterface
`default_nettype wire

[hdl/rect_falloff_mask_pixel.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rect_falloff_mask_pixel
// Rectangular linear-falloff mask height, one pixel per clock unless stalled.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless stalled and returns its mask height, linear
// address and out-of-image flag from two front stages (distance, address, ramp
// numerator), a chain of eight divider cells that each settle one bit of the
// 8-bit ramp quotient for both axes, and an output register that takes the
// smaller axis value. The pipeline drains into its empty stages while the
// output is held. Write configuration only while the pipeline is empty.
module rect_falloff_mask_pixel (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  rfm_in_if.sink                            in_ch,
  rfm_out_if.source                         out_ch,
  input  wire logic                         cfg_we,
  input  wire logic [rfm_pkg::CIDX_W-1:0]   cfg_index,
  input  wire logic [rfm_pkg::CDAT_W-1:0]   cfg_data
);

  rfm_pkg::cfg_t                cfg_r;
  logic [rfm_pkg::DIM_W-1:0]    cfg_u;
  logic [rfm_pkg::DIM_W-1:0]    cfg_dim;

  logic [rfm_pkg::NCELL:0]      ch_valid;
  logic [rfm_pkg::NCELL:0]      ch_ready;
  rfm_pkg::item_t               ch_item [rfm_pkg::NCELL+1];

  logic                         o_valid_r;
  logic [rfm_pkg::HGT_W-1:0]    o_height_r;
  logic [rfm_pkg::ADDR_W-1:0]   o_addr_r;
  logic                         o_outside_r;
  logic [rfm_pkg::HGT_W-1:0]    o_height_nxt;
  logic [rfm_pkg::HGT_W-1:0]    hx;
  logic [rfm_pkg::HGT_W-1:0]    hy;

  assign cfg_u   = cfg_data[rfm_pkg::DIM_W-1:0];
  assign cfg_dim = (cfg_u > rfm_pkg::MAX_DIM) ? rfm_pkg::MAX_DIM : cfg_u;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.map_width     <= 13'd256;
      cfg_r.map_height    <= 13'd256;
      cfg_r.flat_radius_x <= '0;
      cfg_r.flat_radius_y <= '0;
      cfg_r.ramp_width_x  <= '0;
      cfg_r.ramp_width_y  <= '0;
      cfg_r.shift_x       <= '0;
      cfg_r.shift_y       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rfm_pkg::REG_MAP_WIDTH:     cfg_r.map_width     <= cfg_dim;
        rfm_pkg::REG_MAP_HEIGHT:    cfg_r.map_height    <= cfg_dim;
        rfm_pkg::REG_FLAT_RADIUS_X: cfg_r.flat_radius_x <= cfg_u;
        rfm_pkg::REG_FLAT_RADIUS_Y: cfg_r.flat_radius_y <= cfg_u;
        rfm_pkg::REG_RAMP_WIDTH_X:  cfg_r.ramp_width_x  <= cfg_u;
        rfm_pkg::REG_RAMP_WIDTH_Y:  cfg_r.ramp_width_y  <= cfg_u;
        rfm_pkg::REG_SHIFT_X:       cfg_r.shift_x       <= $signed(cfg_data);
        rfm_pkg::REG_SHIFT_Y:       cfg_r.shift_y       <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  rfm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .pix_x     (in_ch.pix_x),
    .pix_y     (in_ch.pix_y),
    .out_valid (ch_valid[0]),
    .out_ready (ch_ready[0]),
    .out_item  (ch_item[0])
  );

  for (genvar i = 0; i < rfm_pkg::NCELL; i++) begin : g_cell
    rfm_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .bit_idx   (3'(rfm_pkg::NCELL - 1 - i)),
      .in_valid  (ch_valid[i]),
      .in_ready  (ch_ready[i]),
      .in_item   (ch_item[i]),
      .out_valid (ch_valid[i+1]),
      .out_ready (ch_ready[i+1]),
      .out_item  (ch_item[i+1])
    );
  end

  assign ch_ready[rfm_pkg::NCELL] = !o_valid_r || out_ch.ready;

  always_comb begin
    hx = rfm_pkg::axis_height(ch_item[rfm_pkg::NCELL].ax_x);
    hy = rfm_pkg::axis_height(ch_item[rfm_pkg::NCELL].ax_y);
    if (ch_item[rfm_pkg::NCELL].outside) begin
      o_height_nxt = '0;
    end else begin
      o_height_nxt = (hx < hy) ? hx : hy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (ch_ready[rfm_pkg::NCELL]) begin
      o_valid_r <= ch_valid[rfm_pkg::NCELL];
    end
  end

  always_ff @(posedge clk) begin
    if (ch_ready[rfm_pkg::NCELL] && ch_valid[rfm_pkg::NCELL]) begin
      o_height_r  <= o_height_nxt;
      o_addr_r    <= ch_item[rfm_pkg::NCELL].addr;
      o_outside_r <= ch_item[rfm_pkg::NCELL].outside;
    end
  end

  assign out_ch.valid         = o_valid_r;
  assign out_ch.height_value  = o_height_r;
  assign out_ch.pixel_address = o_addr_r;
  assign out_ch.outside_image = o_outside_r;

endmodule
`default_nettype wire

[hdl/rfm_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rfm_front
// Two-stage front end: axis distances, address and bounds, then ramp
// classification and divider numerator.
// ----------------------------------------------------------------------------
module rfm_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire rfm_pkg::cfg_t             cfg,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [rfm_pkg::PIX_W-1:0] pix_x,
  input  wire logic [rfm_pkg::PIX_W-1:0] pix_y,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output rfm_pkg::item_t                 out_item
);

  logic                            s1_valid_r;
  logic [rfm_pkg::DST_W-1:0]       s1_dx_r;
  logic [rfm_pkg::DST_W-1:0]       s1_dy_r;
  logic [rfm_pkg::ADDR_W-1:0]      s1_addr_r;
  logic                            s1_outside_r;
  logic                            s2_valid_r;
  rfm_pkg::item_t                  s2_item_r;

  logic                            s1_rdy;
  logic                            s2_rdy;
  logic [24:0]                     prod;
  logic [rfm_pkg::DST_W-1:0]       s1_dx_nxt;
  logic [rfm_pkg::DST_W-1:0]       s1_dy_nxt;
  logic [rfm_pkg::ADDR_W-1:0]      s1_addr_nxt;
  logic                            s1_outside_nxt;
  rfm_pkg::item_t                  s2_item_nxt;

  assign s2_rdy   = !s2_valid_r || out_ready;
  assign s1_rdy   = !s1_valid_r || s2_rdy;
  assign in_ready = s1_rdy;

  always_comb begin
    prod = 25'(pix_y) * 25'(cfg.map_width);
    s1_addr_nxt = prod[rfm_pkg::ADDR_W-1:0] + {12'b0, pix_x};
    s1_outside_nxt = ({1'b0, pix_x} >= cfg.map_width) ||
                     ({1'b0, pix_y} >= cfg.map_height);
    s1_dx_nxt = rfm_pkg::axis_dist(pix_x, cfg.map_width, cfg.shift_x);
    s1_dy_nxt = rfm_pkg::axis_dist(pix_y, cfg.map_height, cfg.shift_y);
  end

  always_comb begin
    s2_item_nxt.ax_x = rfm_pkg::axis_prep(s1_dx_r, cfg.flat_radius_x, cfg.ramp_width_x);
    s2_item_nxt.ax_y = rfm_pkg::axis_prep(s1_dy_r, cfg.flat_radius_y, cfg.ramp_width_y);
    s2_item_nxt.addr = s1_addr_r;
    s2_item_nxt.outside = s1_outside_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_valid_r <= in_valid;
      end
      if (s2_rdy) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_dx_r      <= s1_dx_nxt;
      s1_dy_r      <= s1_dy_nxt;
      s1_addr_r    <= s1_addr_nxt;
      s1_outside_r <= s1_outside_nxt;
    end
    if (s2_rdy && s1_valid_r) begin
      s2_item_r <= s2_item_nxt;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_item  = s2_item_r;

endmodule
`default_nettype wire

[hdl/rfm_div_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rfm_div_cell
// One restoring-division cell: resolves one quotient bit for both axes and
// hands the item to the next cell.
// ----------------------------------------------------------------------------
module rfm_div_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [2:0]                 bit_idx,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire rfm_pkg::item_t             in_item,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output rfm_pkg::item_t                  out_item
);

  logic           valid_r;
  rfm_pkg::item_t item_r;
  rfm_pkg::item_t item_nxt;

  function automatic rfm_pkg::axis_t cell_step(
    input rfm_pkg::axis_t a,
    input logic [2:0]     k
  );
    rfm_pkg::axis_t            b;
    logic [rfm_pkg::REM_W-1:0] dsh;
    b = a;
    dsh = {9'b0, a.den} << k;
    if (a.div && (a.rem >= dsh)) begin
      b.rem = a.rem - dsh;
      b.quo = a.quo | (8'b1 << k);
    end
    return b;
  endfunction

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    item_nxt = in_item;
    item_nxt.ax_x = cell_step(in_item.ax_x, bit_idx);
    item_nxt.ax_y = cell_step(in_item.ax_y, bit_idx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule
`default_nettype wire

[test/testbench.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rectangular falloff mask pipeline.
// ----------------------------------------------------------------------------
// Feeds pixel coordinates under a series of register settings. It starts with
// a directed table covering the reset state, the field extremes, zero and
// saturated image sizes, zero ramps and odd sizes. After that come randomized
// settings, with half of the pixels aimed at the flat area and the ramp edges.
// Every transfer out is compared field by field against an in-bench
// prediction of height, address and outside flag. Both channels idle and
// stall at random. One stretch has no idling at all, and one long output
// hold-off backs up the pipeline.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RUN_LIMIT = 200000;

  typedef struct packed {
    logic [rfm_pkg::HGT_W-1:0]  height;
    logic [rfm_pkg::ADDR_W-1:0] addr;
    logic                       outside;
  } mask_res_t;

  typedef struct packed {
    logic [rfm_pkg::CDAT_W-1:0] width;
    logic [rfm_pkg::CDAT_W-1:0] height;
    logic [rfm_pkg::CDAT_W-1:0] rad_x;
    logic [rfm_pkg::CDAT_W-1:0] rad_y;
    logic [rfm_pkg::CDAT_W-1:0] ramp_x;
    logic [rfm_pkg::CDAT_W-1:0] ramp_y;
    logic [rfm_pkg::CDAT_W-1:0] shf_x;
    logic [rfm_pkg::CDAT_W-1:0] shf_y;
  } mask_setting_t;

  typedef struct packed {
    logic [2:0]                 phase;
    logic [rfm_pkg::PIX_W-1:0]  x;
    logic [rfm_pkg::PIX_W-1:0]  y;
    logic                       typed;
    logic [rfm_pkg::HGT_W-1:0]  h;
    logic [rfm_pkg::ADDR_W-1:0] a;
    logic                       o;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [rfm_pkg::CIDX_W-1:0] cfg_index;
  logic [rfm_pkg::CDAT_W-1:0] cfg_data;

  rfm_in_if  in_ch ();
  rfm_out_if out_ch ();

  rect_falloff_mask_pixel uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // register copies used for prediction
  int mw, mh, rx, ry, fx, fy, sx, sy;

  mask_res_t masks_due[$];
  int errors = 0;
  int results_seen = 0;
  int outside_seen = 0;
  int ramp_seen = 0;
  int settings_applied = 0;
  int send_idle = 0;
  int stall_pct = 0;
  logic hold_ask;
  logic hold_done = 1'b0;
  int hold_left = 0;

  mask_setting_t directed_settings [5] = '{
    '{14'd256, 14'd256, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0},
    '{14'd4096, 14'd4096, 14'd100, 14'd200, 14'd50, 14'd0, 14'd0, 14'd0},
    '{14'd0, 14'd4096, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0},
    '{14'd4095, 14'd17, 14'd3, 14'h2002, 14'd8191, 14'd1, 14'h3000, 14'h1000},
    '{14'h1FFF, 14'd5000, 14'd8191, 14'd0, 14'd1, 14'd4096, 14'h1FFF, 14'h2000}
  };

  pixel_row_t pixel_rows [24] = '{
    '{3'd0, 12'd0,    12'd0,    1'b1, 8'd0,   24'd0,        1'b0},
    '{3'd0, 12'd255,  12'd255,  1'b1, 8'd0,   24'd65535,    1'b0},
    '{3'd0, 12'd256,  12'd0,    1'b1, 8'd0,   24'd256,      1'b1},
    '{3'd0, 12'd0,    12'd256,  1'b1, 8'd0,   24'd65536,    1'b1},
    '{3'd0, 12'd4095, 12'd4095, 1'b1, 8'd0,   24'd1052415,  1'b1},
    '{3'd1, 12'd2048, 12'd2048, 1'b1, 8'd255, 24'd8390656,  1'b0},
    '{3'd1, 12'd4095, 12'd4095, 1'b1, 8'd0,   24'd16777215, 1'b0},
    '{3'd1, 12'd0,    12'd4095, 1'b1, 8'd0,   24'd16773120, 1'b0},
    '{3'd1, 12'd2148, 12'd2048, 1'b0, 8'd0,   24'd0,        1'b0},
    '{3'd1, 12'd2048, 12'd2248, 1'b1, 8'd0,   24'd9209856,  1'b0},
    '{3'd1, 12'd2047, 12'd2247, 1'b0, 8'd0,   24'd0,        1'b0},
    '{3'd1, 12'd2199, 12'd2048, 1'b0, 8'd0,   24'd0,        1'b0},
    '{3'd1, 12'd1998, 12'd2048, 1'b0, 8'd0,   24'd0,        1'b0},
    '{3'd2, 12'd0,    12'd0,    1'b1, 8'd0,   24'd0,        1'b1},
    '{3'd2, 12'd4095, 12'd4095, 1'b1, 8'd0,   24'd4095,     1'b1},
    '{3'd3, 12'd0,    12'd0,    1'b0, 8'd0,   24'd0,        1'b0},
    '{3'd3, 12'd4094, 12'd16,   1'b0, 8'd0,   24'd0,        1'b0},
    '{3'd3, 12'd4095, 12'd0,    1'b0, 8'd0,   24'd0,        1'b0},
    '{3'd3, 12'd0,    12'd17,   1'b0, 8'd0,   24'd0,        1'b0},
    '{3'd3, 12'd2047, 12'd8,    1'b0, 8'd0,   24'd0,        1'b0},
    '{3'd3, 12'd100,  12'd3,    1'b0, 8'd0,   24'd0,        1'b0},
    '{3'd4, 12'd0,    12'd0,    1'b0, 8'd0,   24'd0,        1'b0},
    '{3'd4, 12'd4095, 12'd4095, 1'b0, 8'd0,   24'd0,        1'b0},
    '{3'd4, 12'd2048, 12'd0,    1'b0, 8'd0,   24'd0,        1'b0}
  };

  function automatic int axis_level(int p, int size, int offs, int rad, int ramp);
    int d;
    int e;
    d = 2 * p - (size - 1) - 2 * offs;
    if (d < 0) begin
      d = -d;
    end
    d += size & 1;
    if (d < 2 * rad) begin
      return 255;
    end
    if (ramp == 0) begin
      return 0;
    end
    e = d - 2 * rad;
    if (e >= 2 * ramp) begin
      return 0;
    end
    return (255 * (2 * ramp - e) + ramp) / (2 * ramp);
  endfunction

  function automatic mask_res_t mask_of_pixel(logic [rfm_pkg::PIX_W-1:0] x,
                                              logic [rfm_pkg::PIX_W-1:0] y);
    mask_res_t r;
    int hx;
    int hy;
    r.outside = (int'(x) >= mw) || (int'(y) >= mh);
    r.height = '0;
    if (!r.outside) begin
      hx = axis_level(int'(x), mw, sx, rx, fx);
      hy = axis_level(int'(y), mh, sy, ry, fy);
      r.height = rfm_pkg::HGT_W'(hx < hy ? hx : hy);
    end
    r.addr = rfm_pkg::ADDR_W'(int'(y) * mw + int'(x));
    return r;
  endfunction

  function automatic void model_write(logic [rfm_pkg::CIDX_W-1:0] idx,
                                     logic [rfm_pkg::CDAT_W-1:0] data);
    int u;
    int dim;
    u = int'(data[rfm_pkg::DIM_W-1:0]);
    dim = (u > int'(rfm_pkg::MAX_DIM)) ? int'(rfm_pkg::MAX_DIM) : u;
    case (idx)
      rfm_pkg::REG_MAP_WIDTH:     mw = dim;
      rfm_pkg::REG_MAP_HEIGHT:    mh = dim;
      rfm_pkg::REG_FLAT_RADIUS_X: rx = u;
      rfm_pkg::REG_FLAT_RADIUS_Y: ry = u;
      rfm_pkg::REG_RAMP_WIDTH_X:  fx = u;
      rfm_pkg::REG_RAMP_WIDTH_Y:  fy = u;
      rfm_pkg::REG_SHIFT_X:       sx = int'($signed(data));
      rfm_pkg::REG_SHIFT_Y:       sy = int'($signed(data));
      default: ;
    endcase
  endfunction

  function automatic logic [rfm_pkg::CDAT_W-1:0] pick_dim_word();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) begin
      return '0;
    end else if (k < 4) begin
      return rfm_pkg::CDAT_W'($urandom_range(1, 4));
    end else if (k < 10) begin
      return rfm_pkg::CDAT_W'($urandom_range(5, 64));
    end else if (k < 14) begin
      return rfm_pkg::CDAT_W'($urandom_range(65, 600));
    end else if (k < 17) begin
      return rfm_pkg::CDAT_W'($urandom_range(601, 4095));
    end else if (k < 19) begin
      return rfm_pkg::CDAT_W'(4096);
    end
    return rfm_pkg::CDAT_W'($urandom_range(4097, 16383));
  endfunction

  function automatic logic [rfm_pkg::CDAT_W-1:0] pick_len_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return rfm_pkg::CDAT_W'($urandom_range(1, 8));
      3, 4, 5: return rfm_pkg::CDAT_W'($urandom_range(9, 200));
      6:       return rfm_pkg::CDAT_W'($urandom_range(201, 4096));
      7:       return rfm_pkg::CDAT_W'(8191);
      8:       return rfm_pkg::CDAT_W'($urandom_range(0, 16383));
      default: return rfm_pkg::CDAT_W'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic [rfm_pkg::CDAT_W-1:0] pick_shift_word();
    case ($urandom_range(0, 9))
      0:             return '0;
      1, 2, 3, 4:    return rfm_pkg::CDAT_W'(int'($urandom_range(0, 128)) - 64);
      5, 6:          return rfm_pkg::CDAT_W'(int'($urandom_range(0, 8192)) - 4096);
      7:             return 14'h2000;
      8:             return 14'h1FFF;
      default:       return rfm_pkg::CDAT_W'($urandom_range(0, 16383));
    endcase
  endfunction

  function automatic mask_setting_t random_setting();
    mask_setting_t s;
    s.width = pick_dim_word();
    s.height = pick_dim_word();
    s.rad_x = pick_len_word();
    s.rad_y = pick_len_word();
    s.ramp_x = pick_len_word();
    s.ramp_y = pick_len_word();
    s.shf_x = pick_shift_word();
    s.shf_y = pick_shift_word();
    return s;
  endfunction

  // aim half of the picks at the flat area and ramp around the shifted centre
  function automatic logic [rfm_pkg::PIX_W-1:0] pick_coord(int size, int offs, int rad,
                                                           int ramp);
    int k;
    int c;
    int p;
    k = $urandom_range(0, 9);
    if (k < 2 || size == 0) begin
      return rfm_pkg::PIX_W'($urandom_range(0, 4095));
    end
    if (k < 5) begin
      return rfm_pkg::PIX_W'($urandom_range(0, size - 1));
    end
    c = (size - 1) / 2 + offs;
    p = int'($urandom_range(0, rad + ramp + 2));
    p = $urandom_range(0, 1) ? c + p : c - p;
    if (p < 0) begin
      p = 0;
    end else if (p > size - 1) begin
      p = size - 1;
    end
    return rfm_pkg::PIX_W'(p);
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at result %0d: %s", results_seen, what);
  endtask

  task automatic put_reg(input logic [rfm_pkg::CIDX_W-1:0] idx,
                         input logic [rfm_pkg::CDAT_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    model_write(idx, data);
  endtask

  task automatic apply_setting(input mask_setting_t s);
    put_reg(rfm_pkg::REG_MAP_WIDTH, s.width);
    put_reg(rfm_pkg::REG_MAP_HEIGHT, s.height);
    put_reg(rfm_pkg::REG_FLAT_RADIUS_X, s.rad_x);
    put_reg(rfm_pkg::REG_FLAT_RADIUS_Y, s.rad_y);
    put_reg(rfm_pkg::REG_RAMP_WIDTH_X, s.ramp_x);
    put_reg(rfm_pkg::REG_RAMP_WIDTH_Y, s.ramp_y);
    put_reg(rfm_pkg::REG_SHIFT_X, s.shf_x);
    put_reg(rfm_pkg::REG_SHIFT_Y, s.shf_y);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  task automatic send_pixel(input logic [rfm_pkg::PIX_W-1:0] x,
                            input logic [rfm_pkg::PIX_W-1:0] y,
                            input logic typed, input mask_res_t typed_res);
    in_ch.valid <= 1'b1;
    in_ch.pix_x <= x;
    in_ch.pix_y <= y;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    masks_due.push_back(typed ? typed_res : mask_of_pixel(x, y));
    if ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
  endtask

  // drop valid and wait for the pipeline to drain
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (masks_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_ask && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 79;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    mask_res_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      results_seen++;
      if (out_ch.outside_image === 1'b1) begin
        outside_seen++;
      end else if (out_ch.height_value > 0 && out_ch.height_value < 255) begin
        ramp_seen++;
      end
      if (masks_due.size() == 0) begin
        report_mismatch("result with nothing pending");
      end else begin
        want = masks_due.pop_front();
        if (out_ch.height_value !== want.height) begin
          report_mismatch($sformatf("height_value got %0d want %0d",
                                    out_ch.height_value, want.height));
        end
        if (out_ch.pixel_address !== want.addr) begin
          report_mismatch($sformatf("pixel_address got %0d want %0d",
                                    out_ch.pixel_address, want.addr));
        end
        if (out_ch.outside_image !== want.outside) begin
          report_mismatch($sformatf("outside_image got %b want %b",
                                    out_ch.outside_image, want.outside));
        end
      end
    end
  end

  initial begin
    int i;
    int ph;
    int n;
    int cur;
    pixel_row_t row;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.pix_x <= '0;
    in_ch.pix_y <= '0;
    hold_ask <= 1'b0;
    mw = 256;
    mh = 256;
    rx = 0;
    ry = 0;
    fx = 0;
    fy = 0;
    sx = 0;
    sy = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle = 32;
    stall_pct = 32;

    cur = 0;
    for (i = 0; i < 24; i++) begin
      row = pixel_rows[i];
      if (int'(row.phase) != cur) begin
        cur = int'(row.phase);
        settle();
        apply_setting(directed_settings[cur]);
      end
      send_pixel(row.x, row.y, row.typed, '{row.h, row.a, row.o});
    end

    for (ph = 0; ph < 7; ph++) begin
      settle();
      apply_setting(random_setting());
      send_idle = (ph == 1) ? 0 : 32;
      stall_pct = (ph == 1) ? 0 : 32;
      if (ph == 3) begin
        hold_ask <= 1'b1;
      end
      for (n = 0; n < 100; n++) begin
        send_pixel(pick_coord(mw, sx, rx, fx), pick_coord(mh, sy, ry, fy), 1'b0, '0);
      end
    end

    settle();
    repeat (24) @(posedge clk);
    $display("%0d pixel transfers checked across %0d register settings",
             results_seen, settings_applied);
    $display("%0d fell outside the image, %0d landed on a falloff ramp",
             outside_seen, ramp_seen);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $display("timeout with %0d results pending", masks_due.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
`default_nettype wire
